// ----- rtl/ptlru_pkg.sv -----
`default_nettype none

package ptlru_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_INSERT = 2'd1,
    OUT_EVICT  = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_rd;
    logic out_busy;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ptlru_if.sv -----
`default_nettype none

interface ptlru_req_if;
  import ptlru_pkg::*;

  logic  valid;
  logic  ready;
  addr_t target_addr;
  time_t now_ms;

  modport source (output valid, output target_addr, output now_ms, input ready);
  modport sink (input valid, input target_addr, input now_ms, output ready);
endinterface

interface ptlru_rsp_if;
  import ptlru_pkg::*;

  logic     valid;
  logic     ready;
  outcome_t outcome;
  slot_t    slot_index;
  addr_t    evicted_addr;

  modport source (output valid, output outcome, output slot_index, output evicted_addr,
                  input ready);
  modport sink (input valid, input outcome, input slot_index, input evicted_addr,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/ptlru_ctrl.sv -----
`default_nettype none

module ptlru_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ptlru_pkg::ctl_stat_t stat,
  output ptlru_pkg::ctl_cmd_t       cmd
);
  import ptlru_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.last_rd) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd.start  = (state == ST_IDLE) && in_valid;
    cmd.scan   = (state == ST_SCAN);
    cmd.commit = (state == ST_COMMIT) && !stat.out_busy;
  end

  a_commit_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> (state == ST_COMMIT))
    else $error("drain not followed by commit");

  a_scan_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.scan)
    else $error("scan did not follow start");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan || cmd.commit) |-> !in_ready)
    else $error("ready raised during work");

endmodule

`default_nettype wire

// ----- rtl/ptlru_dp.sv -----
`default_nettype none

module ptlru_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ptlru_pkg::ctl_cmd_t  cmd,
  output ptlru_pkg::ctl_stat_t      stat,
  input  wire ptlru_pkg::addr_t     target_addr,
  input  wire ptlru_pkg::time_t     now_ms,
  ptlru_rsp_if.source               rsp
);
  import ptlru_pkg::*;

  // table storage
  addr_t mem_addr [TABLE_ENTRIES];
  time_t mem_time [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;
  cnt_t  count;

  // request
  addr_t req_addr;
  time_t req_time;

  // scan
  idx_t  rd_idx;
  idx_t  cmp_idx;
  logic  cmp_en;
  addr_t rd_addr_q;
  time_t rd_time_q;

  logic  hit_found;
  idx_t  hit_slot;
  logic  free_found;
  idx_t  free_slot;
  logic  old_found;
  idx_t  old_slot;
  time_t old_time;
  addr_t old_addr;

  // decision
  outcome_t dec_outcome;
  idx_t     dec_slot;
  addr_t    dec_evict;
  logic     dec_insert;

  // output word
  logic     out_valid;
  outcome_t out_outcome;
  slot_t    out_slot;
  addr_t    out_evict;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_addr <= target_addr;
      req_time <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.scan;
      if (cmd.start) begin
        rd_idx <= '0;
      end else if (cmd.scan) begin
        rd_idx <= rd_idx + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (cmd.scan) begin
      rd_addr_q <= mem_addr[rd_idx];
      rd_time_q <= mem_time[rd_idx];
    end
    if (cmd.commit) begin
      mem_addr[dec_slot] <= req_addr;
      mem_time[dec_slot] <= req_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      old_found  <= 1'b0;
    end else if (cmp_en) begin
      if (vld[cmp_idx] && (rd_addr_q == req_addr) && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= cmp_idx;
      end
      if (!vld[cmp_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= cmp_idx;
      end
      if (vld[cmp_idx] && (!old_found || (rd_time_q < old_time))) begin
        old_found <= 1'b1;
        old_slot  <= cmp_idx;
        old_time  <= rd_time_q;
        old_addr  <= rd_addr_q;
      end
    end
  end

  always_comb begin
    dec_insert = 1'b0;
    dec_evict  = '0;
    if (hit_found) begin
      dec_outcome = OUT_HIT;
      dec_slot    = hit_slot;
    end else if (free_found && (count < cnt_t'(TABLE_ENTRIES))) begin
      dec_outcome = OUT_INSERT;
      dec_slot    = free_slot;
      dec_insert  = 1'b1;
    end else begin
      dec_outcome = OUT_EVICT;
      dec_slot    = old_found ? old_slot : '0;
      dec_evict   = old_found ? old_addr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      vld[dec_slot] <= 1'b1;
      if (dec_insert) count <= count + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_outcome <= dec_outcome;
      out_slot    <= slot_t'(dec_slot);
      out_evict   <= dec_evict;
    end
  end

  assign stat.last_rd  = (rd_idx == idx_t'(TABLE_ENTRIES - 1));
  assign stat.out_busy = out_valid && !rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.outcome      = out_outcome;
  assign rsp.slot_index   = out_slot;
  assign rsp.evicted_addr = out_evict;

  a_commit_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !rsp.ready))
    else $error("result overwritten before taken");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(vld) == int'(count))
    else $error("valid count out of step with valid bits");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise output");

  a_evict_only_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && dec_insert) |-> !vld[dec_slot])
    else $error("insert into occupied slot");

endmodule

`default_nettype wire

// ----- rtl/peer_table_lru_insert_top.sv -----
`default_nettype none

// channel  dir  word
// req      in   target_addr[47:0], now_ms[31:0]
// rsp      out  outcome[1:0], slot_index[2:0], evicted_addr[47:0]
//
// after a request is accepted, one entry of the table is read per cycle through a single
// registered read port, then come one drain and one commit step; the result is registered
// at the commit, and a new request is taken only once the control is back in idle
// req ready is high only while no request is in progress
// a finished result waits in the output register, the next request is taken meanwhile
// a stalled rsp holds the next result in its commit step
// rst clears the valid bits, the count and control; the table needs no clearing pass

module peer_table_lru_insert_top (
  input  wire logic   clk,
  input  wire logic   rst,
  ptlru_req_if.sink   req,
  ptlru_rsp_if.source rsp
);
  import ptlru_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      in_ready;

  assign req.ready = in_ready;

  ptlru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptlru_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .target_addr (req.target_addr),
    .now_ms      (req.now_ms),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

// ----- test/peer_table_lru_insert_top_test.sv -----
`timescale 1ns / 100ps

module peer_table_lru_insert_top_test;
  import ptlru_pkg::*;

  typedef struct {
    outcome_t outcome;
    slot_t    slot;
    addr_t    evicted;
  } peer_result_t;

  logic clk;
  logic rst;

  ptlru_req_if req_ch ();
  ptlru_rsp_if rsp_ch ();

  peer_table_lru_insert_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the peer table
  logic  peer_valid  [TABLE_ENTRIES];
  addr_t shadow_addr [TABLE_ENTRIES];
  time_t peer_seen   [TABLE_ENTRIES];
  int    peer_count;

  peer_result_t pending_results [$];
  peer_result_t oldest_result;

  int    mismatches;
  int    words_sent;
  int    results_checked;
  int    hits_seen;
  int    inserts_seen;
  int    evictions_seen;
  int    burst_left;
  bit    sender_bursty;
  bit    rsp_always_ready = 1'b0;
  time_t ms_clock;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic addr_t random_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  function automatic peer_result_t update_peer_table(input addr_t addr, input time_t now);
    peer_result_t res;
    int slot;
    int oldest;
    slot = -1;
    oldest = -1;
    res.evicted = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot < 0 && peer_valid[i] && shadow_addr[i] == addr) slot = i;
    end
    if (slot >= 0) begin
      res.outcome = OUT_HIT;
    end else begin
      if (peer_count < TABLE_ENTRIES) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot < 0 && !peer_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        res.outcome = OUT_INSERT;
        peer_count++;
      end else begin
        // smallest timestamp, lowest index on ties
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (peer_valid[i] && (oldest < 0 || peer_seen[i] < peer_seen[oldest])) oldest = i;
        end
        slot = (oldest < 0) ? 0 : oldest;
        if (peer_valid[slot]) res.evicted = shadow_addr[slot];
        res.outcome = OUT_EVICT;
      end
      peer_valid[slot] = 1'b1;
      shadow_addr[slot] = addr;
    end
    peer_seen[slot] = now;
    res.slot = slot_t'(slot);
    return res;
  endfunction

  task automatic send_request(input addr_t addr, input time_t now);
    req_ch.valid <= 1'b1;
    req_ch.target_addr <= addr;
    req_ch.now_ms <= now;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(update_peer_table(addr, now));
    words_sent++;
    if (sender_bursty) begin
      if (burst_left == 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        burst_left = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  // receiver: rotating stall pattern with occasional long holds
  initial begin
    logic [12:0] stall_pattern;
    int unsigned stall_hold;
    rsp_ch.ready <= 1'b0;
    stall_pattern = 13'h0b5d;
    stall_hold = 0;
    forever begin
      @(posedge clk);
      if (stall_hold != 0) begin
        rsp_ch.ready <= 1'b0;
        stall_hold--;
      end else if (!rsp_always_ready && $urandom_range(0, 149) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_hold = $urandom_range(4, 40);
      end else begin
        rsp_ch.ready <= rsp_always_ready | stall_pattern[0];
      end
      stall_pattern = {stall_pattern[0], stall_pattern[12:1]};
      if ($urandom_range(0, 255) == 0) stall_pattern = 13'($urandom) | 13'h1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected, outcome %0d slot %0d evicted %h",
                 $time, rsp_ch.outcome, rsp_ch.slot_index, rsp_ch.evicted_addr);
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        case (oldest_result.outcome)
          OUT_HIT:    hits_seen++;
          OUT_INSERT: inserts_seen++;
          default:    evictions_seen++;
        endcase
        if (rsp_ch.outcome !== oldest_result.outcome) begin
          mismatches++;
          $display("%0t: outcome expected %0d got %0d",
                   $time, oldest_result.outcome, rsp_ch.outcome);
        end
        if (rsp_ch.slot_index !== oldest_result.slot) begin
          mismatches++;
          $display("%0t: slot_index expected %0d got %0d",
                   $time, oldest_result.slot, rsp_ch.slot_index);
        end
        if (rsp_ch.evicted_addr !== oldest_result.evicted) begin
          mismatches++;
          $display("%0t: evicted_addr expected %h got %h",
                   $time, oldest_result.evicted, rsp_ch.evicted_addr);
        end
      end
    end
  end

  // address zero on an empty table, extreme patterns, a refresh, then the table is filled
  task automatic test_table_fill();
    send_request(48'h0000_0000_0000, 32'd20);
    send_request(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(48'h0000_0000_0000, 32'd40);
    send_request(48'h5555_5555_5555, 32'd20);
    send_request(48'hAAAA_AAAA_AAAA, 32'd20);
    send_request(48'h8000_0000_0000, 32'd20);
    send_request(48'h0000_0000_0001, 32'd20);
    send_request(random_addr(), 32'd20);
    send_request(random_addr(), 32'd20);
  endtask

  // equal timestamps, lowest slot goes first
  task automatic test_timestamp_ties();
    send_request(48'h1234_5678_9ABC, 32'd20);
    send_request(48'h0000_0000_0002, 32'd20);
  endtask

  // all-ones timestamps get evicted like any other
  task automatic test_max_timestamp();
    repeat (7) send_request(random_addr(), 32'hFFFF_FFFF);
    send_request(random_addr(), 32'd0);
    send_request(random_addr(), 32'd1);
  endtask

  task automatic test_random_traffic(input int count, input int pool_size,
                                     input bit bursty, input bit rsp_free);
    addr_t pool [24];
    addr_t addr;
    int pick;
    int roll;
    sender_bursty = bursty;
    burst_left = 0;
    rsp_always_ready <= rsp_free;
    for (int i = 0; i < 24; i++) pool[i] = random_addr();
    repeat (count) begin
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, pool_size - 1);
      if (roll < 75) begin
        addr = pool[pick];
      end else if (roll < 90) begin
        addr = random_addr();
      end else begin
        pool[pick] = random_addr();
        addr = pool[pick];
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) ms_clock = $urandom;
      else if (roll < 7) ms_clock = 32'hFFFF_FF00 + $urandom_range(0, 255);
      else ms_clock = ms_clock + $urandom_range(0, 40);
      send_request(addr, ms_clock);
    end
  endtask

  task automatic finish_run();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * (TABLE_ENTRIES + 3)) @(posedge clk);
    $display("%0d request words sent, %0d results checked", words_sent, results_checked);
    $display("outcomes: %0d hits, %0d inserts, %0d evictions",
             hits_seen, inserts_seen, evictions_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.target_addr <= '0;
    req_ch.now_ms <= '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      peer_valid[i] = 1'b0;
      shadow_addr[i] = '0;
      peer_seen[i] = '0;
    end
    peer_count = 0;
    mismatches = 0;
    words_sent = 0;
    results_checked = 0;
    hits_seen = 0;
    inserts_seen = 0;
    evictions_seen = 0;
    burst_left = 0;
    sender_bursty = 1'b1;
    ms_clock = 32'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_timestamp_ties();
    test_max_timestamp();
    test_random_traffic(180, 6, 1'b1, 1'b0);
    test_random_traffic(180, 16, 1'b0, 1'b1);
    test_random_traffic(180, 10, 1'b1, 1'b1);
    test_random_traffic(180, 24, 1'b0, 1'b0);
    finish_run();
  end

endmodule

// ----- filelist.f -----
rtl/ptlru_pkg.sv
rtl/ptlru_if.sv
rtl/ptlru_ctrl.sv
rtl/ptlru_dp.sv
rtl/peer_table_lru_insert_top.sv
test/peer_table_lru_insert_top_test.sv
